/* design/bmpq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpq_pkg: shared types and codes for the background music priority queue
// Holds the queue entry type, command and emit codes and the sequencer states.
// ----------------------------------------------------------------------------
package bmpq_pkg;

  typedef struct packed {
    logic [7:0] prio;
    logic [7:0] seq;
  } entry_t;

  localparam logic [2:0] CMD_PLAY  = 3'd0;
  localparam logic [2:0] CMD_STOP  = 3'd1;
  localparam logic [2:0] CMD_FADE  = 3'd2;
  localparam logic [2:0] CMD_DROP  = 3'd3;
  localparam logic [2:0] CMD_QUERY = 3'd4;

  localparam logic [1:0] EMIT_NONE  = 2'd0;
  localparam logic [1:0] EMIT_START = 2'd1;
  localparam logic [1:0] EMIT_FADE  = 2'd2;

  localparam logic [15:0] EMPTY_FADE_TIMER = 16'd20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT_UP,
    ST_SHIFT_DN,
    ST_DONE
  } bmpq_state_t;

endpackage

/* design/background_music_priority_queue_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// background_music_priority_queue_top: priority queue of background music
// Keeps up to QUEUE_DEPTH entries ordered by priority and emits the sequence
// commands that play, stop, fadeout and drop requests cause.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one request beat (cmd, player, seq_id, priority_req,
//   fade_time) per handshake. Output channel out_*: exactly one result beat
//   per request, carrying the accept flag, the emitted command and the queue
//   head and size after the request.
//   Play and stop walk the queue one entry per cycle through a single compare
//   unit, then move entries one per cycle through the store's single write
//   port. Fadeout, drop, query and non-queue play requests skip the scan and
//   go straight to the result.
//   in_stall is high from acceptance until the result is loaded into the
//   output register, so one request is in flight at a time; a new request is
//   taken while the previous result still waits at the output.
//   While out_stall holds, the finished result of the next request waits in
//   the sequencer and the output beat holds.
//   Reset empties the queue and drops any pending result; entry contents are
//   not cleared since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module background_music_priority_queue_top #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_player,
  input  logic [7:0]  in_seq_id,
  input  logic [7:0]  in_priority_req,
  input  logic [15:0] in_fade_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [1:0]  out_emit_kind,
  output logic [7:0]  out_emit_player,
  output logic [7:0]  out_emit_value,
  output logic [15:0] out_emit_timer,
  output logic        out_head_valid,
  output logic [7:0]  out_head_priority,
  output logic [7:0]  out_head_sequence,
  output logic [3:0]  out_queue_count
);
  import bmpq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  bmpq_state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic          found_r, found_nxt;

  logic [2:0]  req_cmd_r, req_cmd_nxt;
  logic [7:0]  req_seq_r, req_seq_nxt;
  logic [7:0]  req_prio_r, req_prio_nxt;
  logic [15:0] req_timer_r, req_timer_nxt;

  logic        ok_r, ok_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  eplayer_r, eplayer_nxt;
  logic [7:0]  evalue_r, evalue_nxt;
  logic [15:0] etimer_r, etimer_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_ok_r;
  logic [1:0]  out_kind_r;
  logic [7:0]  out_player_r, out_value_r;
  logic [15:0] out_timer_r;
  logic        out_hvalid_r;
  logic [7:0]  out_hprio_r, out_hseq_r;
  logic [3:0]  out_count_r;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_entry;
  logic [IW-1:0] rd_addr;
  entry_t        rd_entry, head_entry, second_entry;

  logic go_scan, scan_end, seq_hit, prio_hit, out_free, is_play;

  bmpq_store #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_store (
    .clk          (clk),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_entry     (wr_entry),
    .rd_addr      (rd_addr),
    .rd_entry     (rd_entry),
    .head_entry   (head_entry),
    .second_entry (second_entry)
  );

  // Shared compare unit on the addressed entry
  assign seq_hit  = (rd_entry.seq == req_seq_r);
  assign prio_hit = (rd_entry.prio <= req_prio_r);

  assign scan_end = (idx_r == count_r);
  assign is_play  = (req_cmd_r == CMD_PLAY);
  assign out_free = !out_valid_r || !out_stall;
  assign go_scan  = ((in_cmd == CMD_PLAY) && (in_player == 8'd0) && (count_r < DEPTH_C)) ||
                    ((in_cmd == CMD_STOP) && (count_r != '0));

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    unique case (state_r)
      ST_SHIFT_UP: rd_addr = IW'(idx_r - CW'(1));
      ST_SHIFT_DN: rd_addr = IW'(idx_r + CW'(1));
      default:     rd_addr = IW'(idx_r);
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = go_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = is_play ? ST_SHIFT_UP : ST_DONE;
        end else if (seq_hit) begin
          state_nxt = is_play ? ST_DONE : ST_SHIFT_DN;
        end
      end
      ST_SHIFT_UP: begin
        if (IW'(idx_r) == slot_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SHIFT_DN: begin
        if (idx_r >= count_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and store control
  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    found_nxt     = found_r;
    req_cmd_nxt   = req_cmd_r;
    req_seq_nxt   = req_seq_r;
    req_prio_nxt  = req_prio_r;
    req_timer_nxt = req_timer_r;
    ok_nxt        = ok_r;
    kind_nxt      = kind_r;
    eplayer_nxt   = eplayer_r;
    evalue_nxt    = evalue_r;
    etimer_nxt    = etimer_r;
    out_valid_nxt = out_valid_r && out_stall;
    wr_en         = 1'b0;
    wr_addr       = IW'(idx_r);
    wr_entry      = rd_entry;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_cmd_nxt   = in_cmd;
          req_seq_nxt   = in_seq_id;
          req_prio_nxt  = in_priority_req;
          req_timer_nxt = in_fade_time;
          idx_nxt       = '0;
          slot_nxt      = '0;
          found_nxt     = 1'b0;
          ok_nxt        = 1'b1;
          kind_nxt      = EMIT_NONE;
          eplayer_nxt   = 8'd0;
          evalue_nxt    = 8'd0;
          etimer_nxt    = 16'd0;
          unique case (in_cmd)
            CMD_PLAY: begin
              if (in_player != 8'd0) begin
                kind_nxt    = EMIT_START;
                eplayer_nxt = in_player;
                evalue_nxt  = in_seq_id;
                etimer_nxt  = in_fade_time;
              end else if (count_r >= DEPTH_C) begin
                ok_nxt = 1'b0;
              end
            end
            CMD_STOP: begin
              if (count_r == '0) begin
                ok_nxt = 1'b0;
              end
            end
            CMD_FADE: begin
              if ((count_r == '0) || (head_entry.seq != in_seq_id)) begin
                ok_nxt = 1'b0;
              end else begin
                kind_nxt   = EMIT_FADE;
                etimer_nxt = in_fade_time;
              end
            end
            CMD_DROP: begin
              if (count_r != '0) begin
                count_nxt = CW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          if (is_play) begin
            if (slot_r == '0) begin
              // head insert: start it and grow the queue
              kind_nxt   = EMIT_START;
              evalue_nxt = req_seq_r;
              etimer_nxt = req_timer_r;
              count_nxt  = CW'(count_r + CW'(1));
              idx_nxt    = count_r;
              slot_nxt   = '0;
            end else begin
              // insert behind head: tail entry falls off
              idx_nxt = CW'(count_r - CW'(1));
            end
          end else begin
            ok_nxt = 1'b0;
          end
        end else if (seq_hit) begin
          if (is_play) begin
            if (idx_r == '0) begin
              kind_nxt   = EMIT_START;
              evalue_nxt = req_seq_r;
              etimer_nxt = req_timer_r;
            end
          end else begin
            count_nxt = CW'(count_r - CW'(1));
            if (idx_r == '0) begin
              if (count_r != CW'(1)) begin
                kind_nxt   = EMIT_START;
                evalue_nxt = second_entry.seq;
              end else begin
                kind_nxt   = EMIT_FADE;
                etimer_nxt = EMPTY_FADE_TIMER;
              end
            end
          end
        end else begin
          if (!found_r && prio_hit) begin
            found_nxt = 1'b1;
            slot_nxt  = IW'(idx_r);
          end
          idx_nxt = CW'(idx_r + CW'(1));
        end
      end
      ST_SHIFT_UP: begin
        wr_en = 1'b1;
        if (IW'(idx_r) == slot_r) begin
          wr_entry.prio = req_prio_r;
          wr_entry.seq  = req_seq_r;
        end else begin
          idx_nxt = CW'(idx_r - CW'(1));
        end
      end
      ST_SHIFT_DN: begin
        if (idx_r < count_r) begin
          wr_en   = 1'b1;
          idx_nxt = CW'(idx_r + CW'(1));
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    slot_r      <= slot_nxt;
    found_r     <= found_nxt;
    req_cmd_r   <= req_cmd_nxt;
    req_seq_r   <= req_seq_nxt;
    req_prio_r  <= req_prio_nxt;
    req_timer_r <= req_timer_nxt;
    ok_r        <= ok_nxt;
    kind_r      <= kind_nxt;
    eplayer_r   <= eplayer_nxt;
    evalue_r    <= evalue_nxt;
    etimer_r    <= etimer_nxt;
  end

  // Load the result beat once the output register is free
  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      out_ok_r     <= ok_r;
      out_kind_r   <= kind_r;
      out_player_r <= eplayer_r;
      out_value_r  <= evalue_r;
      out_timer_r  <= etimer_r;
      out_hvalid_r <= (count_r != '0);
      out_hprio_r  <= (count_r != '0) ? head_entry.prio : 8'd0;
      out_hseq_r   <= (count_r != '0) ? head_entry.seq : 8'd0;
      out_count_r  <= 4'(count_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_emit_kind     = out_kind_r;
  assign out_emit_player   = out_player_r;
  assign out_emit_value    = out_value_r;
  assign out_emit_timer    = out_timer_r;
  assign out_head_valid    = out_hvalid_r;
  assign out_head_priority = out_hprio_r;
  assign out_head_sequence = out_hseq_r;
  assign out_queue_count   = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("queue count above depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid) |=> (state_r != ST_IDLE))
    else $error("accepted request did not start");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r <= count_r))
    else $error("scan index past queue count");

  a_shift_up_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT_UP) |-> (count_r != '0))
    else $error("insert shift on empty queue");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished result not loaded");

endmodule

/* design/bmpq_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpq_store: queue entry storage
// Entry registers with one write port, one addressed read port and fixed taps
// on the head entry and the entry behind it.
// ----------------------------------------------------------------------------
module bmpq_store #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
  input  bmpq_pkg::entry_t               wr_entry,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
  output bmpq_pkg::entry_t               rd_entry,
  output bmpq_pkg::entry_t               head_entry,
  output bmpq_pkg::entry_t               second_entry
);
  import bmpq_pkg::*;

  entry_t entry_r [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_addr] <= wr_entry;
    end
  end

  assign rd_entry     = entry_r[rd_addr];
  assign head_entry   = entry_r[0];
  assign second_entry = entry_r[1];

endmodule
